/* rtl/limit_order_matcher_top_defines.svh */
// assertion helpers for the rtl, included by lom_seq
`ifndef LIMIT_ORDER_MATCHER_TOP_DEFINES_SVH
`define LIMIT_ORDER_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define LOM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LOM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lom_pkg.sv */
package lom_pkg;

  localparam int unsigned SLOTS = 32;
  localparam int unsigned IDX_W = $clog2(SLOTS);

  typedef enum logic [2:0] {
    KIND_TRADE   = 3'd0,
    KIND_ADDED   = 3'd1,
    KIND_BID     = 3'd2,
    KIND_ASK     = 3'd3,
    KIND_INVALID = 3'd4,
    KIND_FULL    = 3'd5
  } kind_e;

  typedef struct packed {
    logic        side;
    logic [30:0] qty;
    logic [31:0] price;
    logic [62:0] ident;
  } order_t;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [30:0] qty;
    logic [62:0] ident;
    logic [47:0] arrival;
  } slot_t;

  typedef struct packed {
    kind_e       kind;
    logic [35:0] amount;
    logic [31:0] price;
    logic [62:0] ident;
    logic        side;
    logic        last;
  } beat_t;

endpackage

/* rtl/lom_slot_ram.sv */
module lom_slot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/lom_seq.sv */
`include "limit_order_matcher_top_defines.svh"

module lom_seq import lom_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  order_t order_i,
  output logic   emit_valid_o,
  input  logic   emit_ready_i,
  output beat_t  emit_beat_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INV   = 4'd1;
  localparam logic [3:0] S_MSCAN = 4'd2;
  localparam logic [3:0] S_MWAIT = 4'd3;
  localparam logic [3:0] S_MDEC  = 4'd4;
  localparam logic [3:0] S_REST  = 4'd5;
  localparam logic [3:0] S_SSCAN = 4'd6;
  localparam logic [3:0] S_SWAIT = 4'd7;
  localparam logic [3:0] S_SBID  = 4'd8;
  localparam logic [3:0] S_SASK  = 4'd9;
  localparam logic [3:0] S_FLUSH = 4'd10;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [3:0]       state_q, state_d;
  order_t           ord_q;
  logic [30:0]      rem_q;
  logic [IDX_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [SLOTS-1:0] valid_q;
  logic [47:0]      arrival_q;
  logic             bfound_q;
  logic [IDX_W-1:0] bidx_q;
  slot_t            brec_q;
  logic             bid_found_q, ask_found_q;
  logic [31:0]      bid_price_q, ask_price_q;
  logic [35:0]      bid_sum_q, ask_sum_q;
  logic             hold_valid_q;
  beat_t            hold_q;

  logic                      scanning, cnt_last;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  slot_t                     ram_wrec;
  logic [$bits(slot_t)-1:0]  ram_rdata;
  slot_t                     rd_rec;
  logic                      ent_live, other, m_cand, m_better, crossing, trade;
  logic [30:0]               trade_amt, rem_left, bqty_left;
  logic                      free_found;
  logic [IDX_W-1:0]          free_idx;
  logic [36:0]               bid_add, ask_add;
  logic [35:0]               bid_acc, ask_acc;
  logic                      gen_valid, adv;
  beat_t                     gen_beat;

  assign scanning   = (state_q == S_MSCAN) || (state_q == S_SSCAN);
  assign cnt_last   = (cnt_q == LAST_IDX);
  assign in_ready_o = (state_q == S_IDLE);

  lom_slot_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wrec),
    .re_i   (scanning),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  assign rd_rec   = slot_t'(ram_rdata);
  assign ent_live = rd_vld_q && valid_q[rd_idx_q];
  assign other    = ~ord_q.side;
  assign m_cand   = ent_live && (rd_rec.side == other);

  always_comb begin
    if (!bfound_q) begin
      m_better = 1'b1;
    end else if (rd_rec.price != brec_q.price) begin
      m_better = other ? (rd_rec.price < brec_q.price) : (rd_rec.price > brec_q.price);
    end else begin
      m_better = rd_rec.arrival < brec_q.arrival;
    end
  end

  assign crossing  = ord_q.side ? (brec_q.price >= ord_q.price)
                                : (brec_q.price <= ord_q.price);
  assign trade     = bfound_q && crossing;
  assign trade_amt = (rem_q < brec_q.qty) ? rem_q : brec_q.qty;
  assign rem_left  = rem_q - trade_amt;
  assign bqty_left = brec_q.qty - trade_amt;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // saturating level sums
  assign bid_add = {1'b0, bid_sum_q} + {6'd0, rd_rec.qty};
  assign ask_add = {1'b0, ask_sum_q} + {6'd0, rd_rec.qty};
  assign bid_acc = bid_add[36] ? '1 : bid_add[35:0];
  assign ask_acc = ask_add[36] ? '1 : ask_add[35:0];

  always_comb begin
    gen_valid       = 1'b0;
    gen_beat        = '0;
    gen_beat.kind   = KIND_TRADE;
    unique case (state_q)
      S_INV: begin
        gen_valid       = 1'b1;
        gen_beat.kind   = KIND_INVALID;
        gen_beat.amount = {5'd0, ord_q.qty};
        gen_beat.price  = ord_q.price;
        gen_beat.ident  = ord_q.ident;
        gen_beat.side   = ord_q.side;
      end
      S_MDEC: begin
        if (trade) begin
          gen_valid       = 1'b1;
          gen_beat.amount = {5'd0, trade_amt};
          gen_beat.price  = brec_q.price;
          gen_beat.ident  = brec_q.ident;
        end
      end
      S_REST: begin
        if (rem_q != '0) begin
          gen_valid       = 1'b1;
          gen_beat.kind   = free_found ? KIND_ADDED : KIND_FULL;
          gen_beat.amount = {5'd0, rem_q};
          gen_beat.price  = ord_q.price;
          gen_beat.ident  = ord_q.ident;
          gen_beat.side   = ord_q.side;
        end
      end
      S_SBID: begin
        if (bid_found_q) begin
          gen_valid       = 1'b1;
          gen_beat.kind   = KIND_BID;
          gen_beat.amount = bid_sum_q;
          gen_beat.price  = bid_price_q;
        end
      end
      S_SASK: begin
        if (ask_found_q) begin
          gen_valid       = 1'b1;
          gen_beat.kind   = KIND_ASK;
          gen_beat.amount = ask_sum_q;
          gen_beat.price  = ask_price_q;
        end
      end
      default: ;
    endcase
  end

  // one result is held back so the final beat can carry last
  assign adv          = !gen_valid || !hold_valid_q || emit_ready_i;
  assign emit_valid_o = hold_valid_q && (gen_valid || (state_q == S_FLUSH));

  always_comb begin
    emit_beat_o      = hold_q;
    emit_beat_o.last = (state_q == S_FLUSH);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx;
    ram_wrec  = '{side: ord_q.side, price: ord_q.price, qty: rem_q,
                  ident: ord_q.ident, arrival: arrival_q};
    if (state_q == S_MDEC) begin
      ram_we       = trade && adv;
      ram_waddr    = bidx_q;
      ram_wrec     = brec_q;
      ram_wrec.qty = bqty_left;
    end else if (state_q == S_REST) begin
      ram_we = (rem_q != '0) && free_found && adv;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = ((order_i.qty == '0) || (order_i.price == '0)) ? S_INV : S_MSCAN;
        end
      end
      S_INV:   if (adv) state_d = S_FLUSH;
      S_MSCAN: if (cnt_last) state_d = S_MWAIT;
      S_MWAIT: state_d = S_MDEC;
      S_MDEC: begin
        if (!trade) begin
          state_d = S_REST;
        end else if (adv) begin
          state_d = (rem_left != '0) ? S_MSCAN : S_REST;
        end
      end
      S_REST:  if (adv) state_d = S_SSCAN;
      S_SSCAN: if (cnt_last) state_d = S_SWAIT;
      S_SWAIT: state_d = S_SBID;
      S_SBID:  if (adv) state_d = S_SASK;
      S_SASK:  if (adv) state_d = S_FLUSH;
      S_FLUSH: if (emit_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      valid_q      <= '0;
      arrival_q    <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= (scanning && !cnt_last) ? cnt_q + 1'b1 : '0;
      rd_vld_q <= scanning;
      if (state_q == S_MDEC && trade && adv && (bqty_left == '0)) begin
        valid_q[bidx_q] <= 1'b0;
      end
      if (state_q == S_REST && ram_we) begin
        valid_q[free_idx] <= 1'b1;
        arrival_q         <= arrival_q + 48'd1;
      end
      if (gen_valid && adv) begin
        hold_valid_q <= 1'b1;
      end else if (state_q == S_FLUSH && emit_ready_i) begin
        hold_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (state_q == S_IDLE && in_valid_i) begin
      ord_q <= order_i;
      rem_q <= order_i.qty;
    end
    if (state_q == S_MDEC && trade && adv) begin
      rem_q <= rem_left;
    end
    if (gen_valid && adv) begin
      hold_q <= gen_beat;
    end
    if (rd_vld_q) begin
      if (m_cand && m_better) begin
        bfound_q <= 1'b1;
        bidx_q   <= rd_idx_q;
        brec_q   <= rd_rec;
      end
    end else if (state_q == S_MSCAN && cnt_q == '0) begin
      bfound_q <= 1'b0;
    end
    if (rd_vld_q) begin
      if (ent_live && !rd_rec.side) begin
        if (!bid_found_q || rd_rec.price > bid_price_q) begin
          bid_found_q <= 1'b1;
          bid_price_q <= rd_rec.price;
          bid_sum_q   <= {5'd0, rd_rec.qty};
        end else if (rd_rec.price == bid_price_q) begin
          bid_sum_q <= bid_acc;
        end
      end
      if (ent_live && rd_rec.side) begin
        if (!ask_found_q || rd_rec.price < ask_price_q) begin
          ask_found_q <= 1'b1;
          ask_price_q <= rd_rec.price;
          ask_sum_q   <= {5'd0, rd_rec.qty};
        end else if (rd_rec.price == ask_price_q) begin
          ask_sum_q <= ask_acc;
        end
      end
    end else if (state_q == S_SSCAN && cnt_q == '0) begin
      bid_found_q <= 1'b0;
      ask_found_q <= 1'b0;
    end
  end

  `LOM_ASSERT_IMP(a_wr_state, ram_we, (state_q == S_MDEC) || (state_q == S_REST), "write outside update")
  `LOM_ASSERT_IMP(a_rem_live, state_q == S_MSCAN, rem_q != '0, "match scan with no remainder")
  `LOM_ASSERT_IMP(a_fill_free, ram_we && (state_q == S_REST), !valid_q[free_idx], "rest into busy slot")
  `LOM_ASSERT_NXT(a_flush_done, (state_q == S_FLUSH) && emit_ready_i, state_q == S_IDLE, "flush stuck")

endmodule

/* rtl/limit_order_matcher_top.sv */
// an invalid order gives one beat; otherwise the order runs one match pass per trade, plus one
//   unless the last trade empties the order
// throughput: one order at a time, next order taken once the last beat enters the output register
// each scan reads the slot memory one entry per cycle through its single read port
// reset: store empty, arrival count zero, no beat pending
module limit_order_matcher_top import lom_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // quantity[30:0], price[62:31], order_ident[125:63], zero pad
  input  logic [127:0] s_axis_tdata,
  // side
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // amount[35:0], level_price[67:36], ident[130:68], zero pad
  output logic [135:0] m_axis_tdata,
  // kind[2:0], added_side[3]
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  order_t order;
  logic   emit_valid, emit_ready;
  beat_t  emit_beat;
  logic   out_valid_q;
  beat_t  out_q;

  // unpack the order beat
  assign order.side  = s_axis_tuser;
  assign order.qty   = s_axis_tdata[30:0];
  assign order.price = s_axis_tdata[62:31];
  assign order.ident = s_axis_tdata[125:63];

  lom_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .order_i     (order),
    .emit_valid_o(emit_valid),
    .emit_ready_i(emit_ready),
    .emit_beat_o (emit_beat)
  );

  // output register, refilled in the cycle the held beat is taken
  assign emit_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready) begin
      out_valid_q <= emit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready && emit_valid) begin
      out_q <= emit_beat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.ident, out_q.price, out_q.amount};
  assign m_axis_tuser  = {out_q.side, out_q.kind};
  assign m_axis_tlast  = out_q.last;

endmodule
